FILE: rtl/core/acdr_pkg.sv
// Package for the audio crackle detector and repairer.
// Holds word types, fixed-point constants, register indexes and the energy function.
// No dependencies.
package acdr_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int ESHIFT      = 2 * (SAMPLE_BITS - 1);
  localparam int ESHIFT_R    = ESHIFT - 14;

  localparam logic [31:0] ENV_FLOOR = 32'd42950;
  localparam logic [31:0] ENV_MAX   = 32'hFFFF_FFFF;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_AMP_THR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DLT_THR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADJ_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_AMP_DECAY = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DLT_DECAY = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DRY_RUN   = 3'd7;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          is_flush;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          out_valid;
    logic [15:0]                   crackle_count;
    logic                          in_crackle;
  } out_word_t;

  // Q1.32 energy of a squared magnitude; full scale gives 2^32.
  function automatic logic [32:0] energy_of(input logic [2*SAMPLE_BITS-1:0] sq);
    logic [2*SAMPLE_BITS+17:0] sh;
    sh = {sq, 18'b0} >> ESHIFT_R;
    if (sq[2*SAMPLE_BITS-1 -: 2] != 2'b00) begin
      return 33'h1_0000_0000;
    end
    return {1'b0, sh[31:0]};
  endfunction

endpackage

FILE: rtl/core/audio_crackle_detect_repair.sv
// Audio crackle detector and repairer, top level, on acdr_pkg.
// A plain item runs S_AN1 to S_AN3, S_DECIDE, S_FIN and S_OUT; S_OUT waits for a
// free output register, and only then does S_IDLE take the next word: one item in
// flight at a time. Rescan adds S_RS_LOOP, S_RS_WAIT, S_AN1 to S_AN3 and S_RS_CHK
// per rescanned sample; crossfade adds two 16-bit divisions, then S_XF_LOOP, S_XF_RB,
// S_XF_MUL and S_XF_WR per faded sample (one ring read port sets both walks). Reset is
// synchronous; a clearing pass then zeroes the ring, and no word is accepted until it ends.
module audio_crackle_detect_repair
  import acdr_pkg::*;
#(
  parameter int RING_DEPTH = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SB = SAMPLE_BITS;
  localparam int AW = $clog2(RING_DEPTH);
  localparam int PW = AW + 1;
  localparam int RW = (PW > 13) ? PW : 13;
  localparam int CW = (PW > 12) ? PW : 12;

  localparam logic [4:0] S_CLEAR   = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_AN1     = 5'd2;
  localparam logic [4:0] S_AN2     = 5'd3;
  localparam logic [4:0] S_AN3     = 5'd4;
  localparam logic [4:0] S_DECIDE  = 5'd5;
  localparam logic [4:0] S_REDUCE  = 5'd6;
  localparam logic [4:0] S_RS_LOOP = 5'd7;
  localparam logic [4:0] S_RS_WAIT = 5'd8;
  localparam logic [4:0] S_RS_CHK  = 5'd9;
  localparam logic [4:0] S_DIV     = 5'd10;
  localparam logic [4:0] S_XF_LOOP = 5'd11;
  localparam logic [4:0] S_XF_RB   = 5'd12;
  localparam logic [4:0] S_XF_MUL  = 5'd13;
  localparam logic [4:0] S_XF_WR   = 5'd14;
  localparam logic [4:0] S_FIN     = 5'd15;
  localparam logic [4:0] S_OUT     = 5'd16;

  // configuration
  logic [15:0] amp_thr_r, dlt_thr_r, adj_gain_r, amp_decay_r, dlt_decay_r;
  logic [10:0] limit_cfg_r, fade_cfg_r;
  logic        dry_r;
  logic [10:0] limit_eff, fade_eff;
  logic [15:0] adj_eff;

  // ring memory
  logic signed [SB-1:0] ring_mem [RING_DEPTH];
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic signed [SB-1:0] mem_wdata, mem_q_r;

  // control
  logic [4:0]    state_r;
  logic [AW-1:0] clr_r, wp_r, rp_r;
  logic [11:0]   seen_r, run_len_r, len_r;
  logic [15:0]   tally_r;
  logic          scanning_r, flush_r, emit_r, an_ret_r, hit_r, red_xf_r;
  logic          out_valid_r;
  out_word_t     out_word_r;

  // analysis
  logic signed [SB-1:0] an_s_r, prev_sample_r, sav_p_r, pre_p_r;
  logic [31:0] energy_env_r, delta_env_r, sav_e_r, sav_d_r, pre_e_r, pre_d_r;
  logic [32:0] e_s_r, e_p_r;
  logic [31:0] ce_r, cd_r, enve_r, envd_r;
  logic [47:0] pt_e_r, pk_e_r, pt_d_r, pk_d_r;
  logic [48:0] pc_e_r, pc_d_r;

  logic [SB-1:0]        mag_s, mag_p;
  logic signed [34:0]   se_s, se_p, dlt;
  logic [34:0]          adlt;
  logic [31:0]          ce_c, cd_c, enve_c, envd_c;
  logic [16:0]          comp_e, comp_d;
  logic [49:0]          sum_e, sum_d;
  logic                 ha, hd;

  // rescan and crossfade
  logic [RW-1:0]  ra_r, rb_r;
  logic [AW-1:0]  rs_left_r, cr_r, cw_r, cnt_r;
  logic [PW-1:0]  back_a_t, back_b_t;
  logic [AW-1:0]  back_a, back_b;
  logic [PW-1:0]  t_r;
  logic [11:0]    fend_r;
  logic [10:0]    den_r;
  logic [15:0]    q0_r, q1_r, rise_q_r, fall_q_r;
  logic [10:0]    r0_r, r1_r, rise_r_r, fall_r_r;
  logic [11:0]    rr_sum, fr_sum;
  logic           rr_cy, fr_cy;
  logic [15:0]    xf_f;
  logic signed [17:0] fs, wa;
  logic signed [SB-1:0] a_r;
  logic signed [SB+17:0] pa_r, pb_r;
  logic signed [SB+18:0] v_sum, v_adj, v_shr;

  // divider
  logic [15:0] dv_num_r, dv_q_r, dv_q_n;
  logic [10:0] dv_rem_r, dv_rem_n, dv_div;
  logic [11:0] dv_sh;
  logic [3:0]  dv_cnt_r;
  logic        dv_ph_r, dv_ge;

  logic [11:0] rl_inc;
  logic        env_back, emit_n, out_free, in_acc;
  logic signed [SB-1:0] in_s;

  assign limit_eff = (limit_cfg_r < 11'd2) ? 11'd2 : limit_cfg_r;
  assign fade_eff  = (fade_cfg_r == 11'd0) ? 11'd1 : fade_cfg_r;
  assign adj_eff   = (adj_gain_r > 16'd32768) ? 16'd32768 : adj_gain_r;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign in_s      = in_word.is_flush ? '0 : in_word.sample_in;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_thr_r   <= 16'd512;
      dlt_thr_r   <= 16'd512;
      adj_gain_r  <= 16'd32768;
      limit_cfg_r <= 11'd256;
      fade_cfg_r  <= 11'd44;
      amp_decay_r <= 16'd65000;
      dlt_decay_r <= 16'd65000;
      dry_r       <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_AMP_THR:   amp_thr_r   <= cfg_data;
        CFG_DLT_THR:   dlt_thr_r   <= cfg_data;
        CFG_ADJ_GAIN:  adj_gain_r  <= cfg_data;
        CFG_LIMIT:     limit_cfg_r <= cfg_data[10:0];
        CFG_FADE:      fade_cfg_r  <= cfg_data[10:0];
        CFG_AMP_DECAY: amp_decay_r <= cfg_data;
        CFG_DLT_DECAY: dlt_decay_r <= cfg_data;
        CFG_DRY_RUN:   dry_r       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) ring_mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_q_r <= ring_mem[mem_raddr];
  end

  // analysis datapath
  assign mag_s  = an_s_r[SB-1] ? SB'(-an_s_r) : an_s_r;
  assign mag_p  = prev_sample_r[SB-1] ? SB'(-prev_sample_r) : prev_sample_r;
  assign ce_c   = e_s_r[32] ? ENV_MAX : e_s_r[31:0];
  assign se_s   = an_s_r[SB-1] ? -$signed({2'b0, e_s_r}) : $signed({2'b0, e_s_r});
  assign se_p   = prev_sample_r[SB-1] ? -$signed({2'b0, e_p_r}) : $signed({2'b0, e_p_r});
  assign dlt    = se_p - se_s;
  assign adlt   = dlt[34] ? 35'(-dlt) : 35'(dlt);
  assign cd_c   = (adlt[34:32] != 3'b000) ? ENV_MAX : adlt[31:0];
  assign enve_c = (energy_env_r == 32'd0) ? ENV_FLOOR : energy_env_r;
  assign envd_c = (delta_env_r == 32'd0) ? ENV_FLOOR : delta_env_r;
  assign comp_e = 17'h1_0000 - {1'b0, amp_decay_r};
  assign comp_d = 17'h1_0000 - {1'b0, dlt_decay_r};
  assign sum_e  = {2'b0, pk_e_r} + {1'b0, pc_e_r};
  assign sum_d  = {2'b0, pk_d_r} + {1'b0, pc_d_r};
  assign ha     = {8'b0, ce_r, 8'b0} >= pt_e_r;
  assign hd     = {8'b0, cd_r, 8'b0} >= pt_d_r;

  // ring walk helpers
  assign back_a_t = {1'b0, wp_r} + PW'(RING_DEPTH) - {1'b0, ra_r[AW-1:0]};
  assign back_b_t = {1'b0, wp_r} + PW'(RING_DEPTH) - {1'b0, rb_r[AW-1:0]};
  assign back_a   = (back_a_t >= PW'(RING_DEPTH)) ? AW'(back_a_t - PW'(RING_DEPTH))
                                                  : back_a_t[AW-1:0];
  assign back_b   = (back_b_t >= PW'(RING_DEPTH)) ? AW'(back_b_t - PW'(RING_DEPTH))
                                                  : back_b_t[AW-1:0];

  assign rr_sum = {1'b0, rise_r_r} + {1'b0, r0_r};
  assign rr_cy  = rr_sum >= {1'b0, fade_eff};
  assign fr_sum = {1'b0, fall_r_r} + {1'b0, r1_r};
  assign fr_cy  = fr_sum >= {1'b0, den_r};
  assign xf_f   = rise_q_r - fall_q_r;
  assign fs     = $signed({2'b0, xf_f});
  assign wa     = 18'sd32768 - fs;
  assign v_sum  = (SB+19)'(pa_r) + (SB+19)'(pb_r);
  assign v_adj  = v_sum[SB+18] ? v_sum + (SB+19)'(32767) : v_sum;
  assign v_shr  = v_adj >>> 15;

  assign dv_div   = dv_ph_r ? den_r : fade_eff;
  assign dv_sh    = {dv_rem_r, dv_num_r[15]};
  assign dv_ge    = dv_sh >= {1'b0, dv_div};
  assign dv_rem_n = dv_ge ? 11'(dv_sh - {1'b0, dv_div}) : dv_sh[10:0];
  assign dv_q_n   = {dv_q_r[14:0], dv_ge};

  assign rl_inc   = run_len_r + 12'd1;
  assign env_back = (energy_env_r <= sav_e_r) && (delta_env_r <= sav_d_r);
  assign emit_n   = !dry_r && (flush_r || (seen_r >= {1'b0, limit_eff}));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wp_r;
    mem_wdata = in_s;
    mem_re    = 1'b0;
    mem_raddr = cr_r;
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
      end
      S_IDLE:    mem_we = in_acc;
      S_RS_LOOP: mem_re = (rs_left_r != '0);
      S_XF_LOOP: begin
        mem_re    = (t_r != {1'b0, cnt_r});
        mem_raddr = cw_r;
      end
      S_XF_RB:   mem_re = 1'b1;
      S_XF_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cw_r;
        mem_wdata = v_shr[SB-1:0];
      end
      S_FIN: begin
        mem_re    = emit_n;
        mem_raddr = rp_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_r         <= '0;
      wp_r          <= '0;
      rp_r          <= '0;
      seen_r        <= '0;
      run_len_r     <= '0;
      tally_r       <= '0;
      scanning_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      energy_env_r  <= '0;
      delta_env_r   <= '0;
      prev_sample_r <= '0;
      sav_e_r       <= '0;
      sav_d_r       <= '0;
      sav_p_r       <= '0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_OUT)) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(RING_DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            an_s_r   <= in_s;
            flush_r  <= in_word.is_flush;
            pre_e_r  <= energy_env_r;
            pre_d_r  <= delta_env_r;
            pre_p_r  <= prev_sample_r;
            an_ret_r <= 1'b0;
            state_r  <= S_AN1;
          end
        end
        S_AN1: begin
          e_s_r   <= energy_of(mag_s * mag_s);
          e_p_r   <= energy_of(mag_p * mag_p);
          state_r <= S_AN2;
        end
        S_AN2: begin
          ce_r    <= ce_c;
          cd_r    <= cd_c;
          enve_r  <= enve_c;
          envd_r  <= envd_c;
          pt_e_r  <= amp_thr_r * enve_c;
          pk_e_r  <= amp_decay_r * enve_c;
          pc_e_r  <= comp_e * ce_c;
          pt_d_r  <= dlt_thr_r * envd_c;
          pk_d_r  <= dlt_decay_r * envd_c;
          pc_d_r  <= comp_d * cd_c;
          state_r <= S_AN3;
        end
        S_AN3: begin
          energy_env_r  <= (ce_r > enve_r) ? ce_r : sum_e[47:16];
          delta_env_r   <= (cd_r > envd_r) ? cd_r : sum_d[47:16];
          prev_sample_r <= an_s_r;
          hit_r         <= ha && hd;
          state_r       <= an_ret_r ? S_RS_CHK : S_DECIDE;
        end
        S_DECIDE: begin
          if (scanning_r) begin
            if (env_back) begin
              scanning_r <= 1'b0;
              run_len_r  <= '0;
              if (dry_r) begin
                if (tally_r != 16'hFFFF) tally_r <= tally_r + 16'd1;
                state_r <= S_FIN;
              end else begin
                len_r    <= rl_inc;
                ra_r     <= RW'(rl_inc) + RW'(fade_eff);
                rb_r     <= RW'({rl_inc, 1'b0}) + RW'(fade_eff);
                fend_r   <= (rl_inc > {1'b0, fade_eff}) ? rl_inc : {1'b0, fade_eff};
                den_r    <= (rl_inc > {1'b0, fade_eff}) ? fade_eff : rl_inc[10:0];
                red_xf_r <= 1'b1;
                state_r  <= S_REDUCE;
              end
            end else if (rl_inc >= {1'b0, limit_eff}) begin
              run_len_r <= rl_inc;
              len_r     <= rl_inc - 12'd1;
              ra_r      <= RW'(rl_inc - 12'd1);
              rb_r      <= '0;
              red_xf_r  <= 1'b0;
              state_r   <= S_REDUCE;
            end else begin
              run_len_r <= rl_inc;
              state_r   <= S_FIN;
            end
          end else begin
            state_r <= S_FIN;
            if (hit_r) begin
              scanning_r <= 1'b1;
              run_len_r  <= '0;
              sav_e_r    <= pre_e_r;
              sav_d_r    <= pre_d_r;
              sav_p_r    <= pre_p_r;
            end
          end
        end
        S_REDUCE: begin
          if (ra_r >= RW'(RING_DEPTH) || rb_r >= RW'(RING_DEPTH)) begin
            if (ra_r >= RW'(RING_DEPTH)) ra_r <= ra_r - RW'(RING_DEPTH);
            if (rb_r >= RW'(RING_DEPTH)) rb_r <= rb_r - RW'(RING_DEPTH);
          end else if (red_xf_r) begin
            dv_num_r <= adj_eff;
            dv_rem_r <= '0;
            dv_q_r   <= '0;
            dv_cnt_r <= '0;
            dv_ph_r  <= 1'b0;
            state_r  <= S_DIV;
          end else begin
            rs_left_r     <= ra_r[AW-1:0];
            cr_r          <= back_a;
            energy_env_r  <= sav_e_r;
            delta_env_r   <= sav_d_r;
            prev_sample_r <= sav_p_r;
            state_r       <= S_RS_LOOP;
          end
        end
        S_RS_LOOP: begin
          if (rs_left_r == '0) begin
            run_len_r  <= len_r;
            scanning_r <= 1'b0;
            state_r    <= S_FIN;
          end else begin
            state_r <= S_RS_WAIT;
          end
        end
        S_RS_WAIT: begin
          an_s_r   <= mem_q_r;
          an_ret_r <= 1'b1;
          state_r  <= S_AN1;
        end
        S_RS_CHK: begin
          if (hit_r) begin
            sav_e_r   <= pre_e_r;
            sav_d_r   <= pre_d_r;
            sav_p_r   <= pre_p_r;
            run_len_r <= len_r;
            state_r   <= S_FIN;
          end else begin
            len_r     <= len_r - 12'd1;
            cr_r      <= (cr_r == AW'(RING_DEPTH - 1)) ? '0 : cr_r + 1'b1;
            rs_left_r <= rs_left_r - 1'b1;
            state_r   <= S_RS_LOOP;
          end
        end
        S_DIV: begin
          if (dv_cnt_r == 4'd15) begin
            dv_num_r <= adj_eff;
            dv_rem_r <= '0;
            dv_q_r   <= '0;
            dv_cnt_r <= '0;
            dv_ph_r  <= 1'b1;
            if (!dv_ph_r) begin
              q0_r <= dv_q_n;
              r0_r <= dv_rem_n;
            end else begin
              q1_r     <= dv_q_n;
              r1_r     <= dv_rem_n;
              cnt_r    <= ra_r[AW-1:0];
              cw_r     <= back_a;
              cr_r     <= back_b;
              t_r      <= '0;
              rise_q_r <= '0;
              rise_r_r <= '0;
              fall_q_r <= '0;
              fall_r_r <= '0;
              state_r  <= S_XF_LOOP;
            end
          end else begin
            dv_num_r <= {dv_num_r[14:0], 1'b0};
            dv_rem_r <= dv_rem_n;
            dv_q_r   <= dv_q_n;
            dv_cnt_r <= dv_cnt_r + 4'd1;
          end
        end
        S_XF_LOOP: begin
          state_r <= (t_r == {1'b0, cnt_r}) ? S_FIN : S_XF_RB;
        end
        S_XF_RB: begin
          a_r     <= mem_q_r;
          state_r <= S_XF_MUL;
        end
        S_XF_MUL: begin
          pa_r    <= a_r * wa;
          pb_r    <= mem_q_r * fs;
          state_r <= S_XF_WR;
        end
        S_XF_WR: begin
          cw_r <= (cw_r == AW'(RING_DEPTH - 1)) ? '0 : cw_r + 1'b1;
          cr_r <= (cr_r == AW'(RING_DEPTH - 1)) ? '0 : cr_r + 1'b1;
          t_r  <= t_r + 1'b1;
          if (CW'(t_r) < CW'(fade_eff)) begin
            rise_q_r <= rise_q_r + q0_r + 16'(rr_cy);
            rise_r_r <= rr_cy ? 11'(rr_sum - {1'b0, fade_eff}) : rr_sum[10:0];
          end
          if (CW'(t_r) >= CW'(fend_r)) begin
            fall_q_r <= fall_q_r + q1_r + 16'(fr_cy);
            fall_r_r <= fr_cy ? 11'(fr_sum - {1'b0, den_r}) : fr_sum[10:0];
          end
          state_r <= S_XF_LOOP;
        end
        S_FIN: begin
          emit_r  <= emit_n;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_word_r  <= '{sample_out: (emit_r ? mem_q_r : '0), out_valid: emit_r,
                             crackle_count: tally_r, in_crackle: scanning_r};
            out_valid_r <= 1'b1;
            if (emit_r) rp_r <= (rp_r == AW'(RING_DEPTH - 1)) ? '0 : rp_r + 1'b1;
            if (seen_r < {1'b0, limit_eff}) seen_r <= seen_r + 12'd1;
            wp_r    <= (wp_r == AW'(RING_DEPTH - 1)) ? '0 : wp_r + 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_starts_analysis: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_AN1)
    else $error("accepted word did not start analysis");

  a_dry_emits_nothing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.out_valid |-> !dry_r)
    else $error("sample emitted in dry mode");

  a_empty_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.out_valid |-> out_word.sample_out == '0)
    else $error("nonzero sample without valid flag");

  a_fade_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_XF_MUL |-> rise_q_r >= fall_q_r && xf_f <= adj_eff)
    else $error("crossfade weight out of range");
`endif

endmodule

FILE: tb/tb_audio_crackle_detect_repair.sv
// Self-checking bench for audio_crackle_detect_repair: clocked driver and monitor,
// a cycle-free predictor of envelopes, rescans and crossfades, and config phases.
// Depends on acdr_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_audio_crackle_detect_repair;
  import acdr_pkg::*;

  localparam int RING = 4096;
  localparam int WATCHDOG = 200000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_word_t in_word;
  logic out_valid;
  logic out_ready;
  out_word_t out_word;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  audio_crackle_detect_repair u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  in_word_t  sample_q[$];
  out_word_t repaired_q[$];
  int errors;
  int n_in;
  int n_out;
  int quiet_cycles;
  bit in_fire;
  bit held;
  int hold_left;

  // predictor state
  int ring[RING];
  longint unsigned e_env, d_env, e_saved, d_saved;
  int prev_s, prev_saved;
  bit scanning;
  int unsigned run_len, wr_ptr, rd_ptr, seen, tally;
  int unsigned amp_thr, dlt_thr, adj_gain, limit_reg, fade_reg, amp_dec, dlt_dec, dry;

  function automatic longint unsigned energy(int s);
    longint unsigned m;
    longint unsigned sq;
    m = (s < 0) ? -s : s;
    sq = m * m;
    if (sq >= (64'd1 << 30)) return 64'd1 << 32;
    return (sq << 18) >> 16;
  endfunction

  function automatic longint signed_energy(int s);
    longint e;
    e = energy(s);
    return (s < 0) ? -e : e;
  endfunction

  function automatic longint unsigned decay_env(longint unsigned env, longint unsigned cur,
                                                 int unsigned k);
    if (cur > env) return cur;
    return (k * env + (65536 - k) * cur) >> 16;
  endfunction

  function bit detect(int s);
    longint unsigned ce;
    longint unsigned cd;
    longint d;
    bit ha;
    bit hd;
    ce = energy(s);
    if (ce > 64'hFFFF_FFFF) ce = 64'hFFFF_FFFF;
    if (e_env == 0) e_env = 42950;
    ha = ce * 256 >= amp_thr * e_env;
    e_env = decay_env(e_env, ce, amp_dec);
    d = signed_energy(prev_s) - signed_energy(s);
    cd = (d < 0) ? -d : d;
    if (cd > 64'hFFFF_FFFF) cd = 64'hFFFF_FFFF;
    if (d_env == 0) d_env = 42950;
    hd = cd * 256 >= dlt_thr * d_env;
    d_env = decay_env(d_env, cd, dlt_dec);
    prev_s = s;
    return ha && hd;
  endfunction

  function int unsigned behind(int unsigned n);
    return (wr_ptr + RING - (n % RING)) % RING;
  endfunction

  function void blend(int unsigned len);
    int unsigned fade, cnt, cw, cr, fend, den, t, inc, dec;
    longint adj, f, v;
    fade = fade_reg ? fade_reg : 1;
    adj = adj_gain > 32768 ? 32768 : adj_gain;
    cnt = (len + fade) % RING;
    cw = behind(len + fade);
    cr = behind(2 * len + fade);
    fend = len > fade ? len : fade;
    den = len > fade ? fade : len;
    for (t = 0; t < cnt; t++) begin
      inc = t < fade ? t : fade;
      dec = t > fend ? t - fend : 0;
      f = adj * inc / fade - adj * dec / den;
      v = (longint'(ring[cw]) * (32768 - f) + longint'(ring[cr]) * f) / 32768;
      ring[cw] = int'(v);
      cw = (cw + 1) % RING;
      cr = (cr + 1) % RING;
    end
  endfunction

  function out_word_t repair_step(in_word_t w);
    out_word_t r;
    int s;
    int unsigned lim, len, steps, i, cr;
    longint unsigned pre_e, pre_d;
    int pre_p;
    bit start, emit, found;
    lim = limit_reg < 2 ? 2 : limit_reg;
    pre_e = e_env;
    pre_d = d_env;
    pre_p = prev_s;
    s = w.is_flush ? 0 : int'(w.sample_in);
    ring[wr_ptr] = s;
    start = detect(s);
    if (scanning) begin
      run_len++;
      if (e_env <= e_saved && d_env <= d_saved) begin
        if (dry) begin
          if (tally < 16'hFFFF) tally++;
        end else begin
          blend(run_len);
        end
        scanning = 0;
        run_len = 0;
      end else if (run_len >= lim) begin
        len = run_len - 1;
        steps = len % RING;
        cr = behind(len);
        found = 0;
        e_env = e_saved;
        d_env = d_saved;
        prev_s = prev_saved;
        for (i = 0; i < steps; i++) begin
          if (detect(ring[cr])) begin
            e_saved = pre_e;
            d_saved = pre_d;
            prev_saved = pre_p;
            found = 1;
            break;
          end
          len--;
          cr = (cr + 1) % RING;
        end
        if (!found) scanning = 0;
        run_len = len;
      end
    end else if (start) begin
      scanning = 1;
      run_len = 0;
      e_saved = pre_e;
      d_saved = pre_d;
      prev_saved = pre_p;
    end
    emit = !dry && (w.is_flush || seen >= lim);
    r = '0;
    if (emit) begin
      r.sample_out = ring[rd_ptr][15:0];
      rd_ptr = (rd_ptr + 1) % RING;
    end
    if (seen < lim) seen++;
    wr_ptr = (wr_ptr + 1) % RING;
    r.out_valid = emit;
    r.crackle_count = tally[15:0];
    r.in_crackle = scanning;
    return r;
  endfunction

  function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_AMP_THR:   amp_thr = d;
      CFG_DLT_THR:   dlt_thr = d;
      CFG_ADJ_GAIN:  adj_gain = d;
      CFG_LIMIT:     limit_reg = d[10:0];
      CFG_FADE:      fade_reg = d[10:0];
      CFG_AMP_DECAY: amp_dec = d;
      CFG_DLT_DECAY: dlt_dec = d;
      CFG_DRY_RUN:   dry = d[0];
      default: ;
    endcase
  endfunction

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // monitor, predictor feed and watchdog
  always @(posedge clk) begin
    out_word_t exp_w;
    in_fire <= in_valid && in_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        repaired_q.push_back(repair_step(in_word));
        n_in++;
      end
      if (out_valid && out_ready) begin
        n_out++;
        if (repaired_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word %p", out_word);
        end else begin
          exp_w = repaired_q.pop_front();
          if (exp_w.sample_out !== out_word.sample_out ||
              exp_w.out_valid !== out_word.out_valid ||
              exp_w.crackle_count !== out_word.crackle_count ||
              exp_w.in_crackle !== out_word.in_crackle) begin
            errors++;
            if (errors <= 10) $display("word %0d: expected %p, got %p", n_out, exp_w, out_word);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (sample_q.size() == 0 || (!(n_in > 60 && n_in < 100) && $urandom_range(99) < 16)) begin
        in_valid <= 0;
      end else begin
        in_word <= sample_q.pop_front();
        in_valid <= 1;
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 0;
    end else if (!held && n_out == 40) begin
      held <= 1;
      hold_left <= 300;
      out_ready <= 0;
    end else begin
      out_ready <= (n_in > 60 && n_in < 100) ? 1'b1 : ($urandom_range(99) >= 16);
    end
  end

  task automatic push_sample(int s, bit fl);
    in_word_t w;
    w.sample_in = s[15:0];
    w.is_flush = fl;
    sample_q.push_back(w);
  endtask

  task automatic push_crackles(int n);
    int i, k;
    for (i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 70) begin
        repeat ($urandom_range(3, 8)) push_sample(int'($urandom_range(200)) - 100, 0);
        repeat ($urandom_range(1, 3))
          push_sample(($urandom_range(1) ? 1 : -1) * int'($urandom_range(8000, 32767)), 0);
        repeat ($urandom_range(2, 10)) push_sample(int'($urandom_range(200)) - 100, 0);
      end else if (k < 85) begin
        push_sample(int'($urandom_range(65535)) - 32768, 0);
      end else begin
        push_sample(int'($urandom_range(65535)) - 32768, 1);
      end
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned d);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= d[15:0];
    cfg_valid <= 1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic drain();
    do @(posedge clk); while (sample_q.size() != 0 || in_valid || repaired_q.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_all(int unsigned at, int unsigned dt, int unsigned ag, int unsigned lm,
                         int unsigned fd, int unsigned ad, int unsigned dd, int unsigned dr);
    write_reg(CFG_AMP_THR, at);
    write_reg(CFG_DLT_THR, dt);
    write_reg(CFG_ADJ_GAIN, ag);
    write_reg(CFG_LIMIT, lm);
    write_reg(CFG_FADE, fd);
    write_reg(CFG_AMP_DECAY, ad);
    write_reg(CFG_DLT_DECAY, dd);
    write_reg(CFG_DRY_RUN, dr);
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_word = '0;
    out_ready = 0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    n_in = 0;
    n_out = 0;
    quiet_cycles = 0;
    held = 0;
    hold_left = 0;
    foreach (ring[i]) ring[i] = 0;
    e_env = 0; d_env = 0; e_saved = 0; d_saved = 0;
    prev_s = 0; prev_saved = 0; scanning = 0;
    run_len = 0; wr_ptr = 0; rd_ptr = 0; seen = 0; tally = 0;
    amp_thr = 512; dlt_thr = 512; adj_gain = 32768; limit_reg = 256;
    fade_reg = 44; amp_dec = 65000; dlt_dec = 65000; dry = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: field extremes, flushes, a clear spike, at default settings
    push_sample(0, 0);
    push_sample(32767, 0);
    push_sample(-32768, 0);
    push_sample(-1, 0);
    push_sample(1, 0);
    push_sample(0, 1);
    push_sample(-32768, 1);
    repeat (4) push_sample(50, 0);
    push_sample(30000, 0);
    push_sample(-30000, 0);
    repeat (4) push_sample(-40, 0);
    push_sample(12345, 1);
    push_sample(32767, 1);
    drain();

    // smallest limit and fade, fast decay
    set_all(512, 512, 32768, 2, 1, 0, 0, 0);
    push_crackles(2);
    drain();

    // short limit, partial repair, rescans and crossfades
    set_all(512, 512, 16384, 16, 8, 20000, 20000, 0);
    push_crackles(3);
    drain();

    // out-of-range settings: limit below two, zero fade, excess gain
    set_all(0, 65535, 65535, 0, 0, 65535, 40000, 0);
    push_crackles(2);
    drain();

    // dry mode counting, including dry flushes; then lower the limit mid-scan
    set_all(256, 256, 32768, 64, 1024, 30000, 30000, 1);
    push_crackles(2);
    drain();
    write_reg(CFG_LIMIT, 3);
    push_crackles(2);
    drain();

    // large limit and fade, no repair depth
    set_all(65535, 0, 0, 1536, 1024, 65000, 65000, 0);
    push_crackles(1);
    repeat (6) push_sample(int'($urandom_range(65535)) - 32768, 1);
    drain();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
